>>> rtl/core/wlst_pkg.sv
// Shared types and constants of the word and line span tokenizer.
`default_nettype none

package wlst_pkg;

	// Record kinds on the result channel.
	localparam logic [1:0] KIND_LINE  = 2'd0;
	localparam logic [1:0] KIND_WORD  = 2'd1;
	localparam logic [1:0] KIND_TOTAL = 2'd2;

	// Code units of the basic and extended sets.
	localparam logic [15:0] CU_CR    = 16'h000D;
	localparam logic [15:0] CU_LF    = 16'h000A;
	localparam logic [15:0] CU_SPACE = 16'h0020;
	localparam logic [15:0] CU_TAB   = 16'h0009;
	localparam logic [15:0] CU_LSEP  = 16'h2028;
	localparam logic [15:0] CU_PSEP  = 16'h2029;
	localparam logic [15:0] CU_NEL   = 16'h0085;

	// Most records that one code unit can cause.
	localparam int unsigned MAX_RECS = 3;

	// Class of one code unit.
	typedef struct packed {
		logic newline;
		logic space;
	} unit_class_t;

	// One result record as it leaves the block.
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] start;
		logic [16:0] length;
		logic [16:0] nonspace;
		logic [16:0] words;
		logic [16:0] lines;
		logic        last;
	} record_t;

endpackage

`default_nettype wire

>>> rtl/core/wlst_classify.sv
// Code unit classifier: newline and whitespace detection.
`default_nettype none

module wlst_classify (
	input  wire logic [15:0]         code_unit,
	input  wire logic                extended,
	output wlst_pkg::unit_class_t    unit_class
);

	logic basic_nl;
	logic ext_nl;
	logic blank;

	// Compare the unit against each fixed set.
	always_comb begin
		basic_nl = code_unit inside {wlst_pkg::CU_CR, wlst_pkg::CU_LF};
		ext_nl   = code_unit inside {wlst_pkg::CU_LSEP, wlst_pkg::CU_PSEP, wlst_pkg::CU_NEL};
		blank    = code_unit inside {wlst_pkg::CU_SPACE, wlst_pkg::CU_TAB};
	end

	// The extended units join both sets only when the mode is on.
	assign unit_class.newline = basic_nl | (extended & ext_nl);
	assign unit_class.space   = unit_class.newline | blank;

endmodule

`default_nettype wire

>>> rtl/core/wlst_span_state.sv
// Open line and word state, counters, and the record list of one code unit.
`default_nettype none

module wlst_span_state #(
	parameter int unsigned MAX_TEXT_UNITS = 65536
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire wlst_pkg::unit_class_t unit_class,
	input  wire logic                  end_of_text,
	input  wire logic                  retire,
	output wlst_pkg::record_t          recs [wlst_pkg::MAX_RECS],
	output logic [1:0]                 rec_count
);

	localparam int unsigned CW = $clog2(MAX_TEXT_UNITS + 1);
	localparam int unsigned OW = (CW > 17) ? CW : 17;
	localparam logic [CW-1:0] MAXV = CW'(MAX_TEXT_UNITS);
	localparam logic [OW-1:0] LAST_IDX = OW'(MAX_TEXT_UNITS - 1);
	localparam int unsigned NCAND = 5;

	logic          in_line_q;
	logic          in_word_q;
	logic [15:0]   line_begin_q;
	logic [15:0]   word_begin_q;
	logic [CW-1:0] line_run_q;
	logic [CW-1:0] word_run_q;
	logic [CW-1:0] position_q;
	logic [CW-1:0] nonspace_q;
	logic [CW-1:0] words_q;
	logic [CW-1:0] lines_q;

	logic [15:0]   idx;
	logic          line_close;
	logic          word_close;
	logic          in_line1;
	logic          in_word1;
	logic [15:0]   line_begin1;
	logic [15:0]   word_begin1;
	logic [CW-1:0] line_run1;
	logic [CW-1:0] word_run1;
	logic [CW-1:0] nonspace1;
	logic [CW-1:0] lines1;
	logic [CW-1:0] words1;
	logic [CW-1:0] lines_f;
	logic [CW-1:0] words_f;

	wlst_pkg::record_t cand [NCAND];
	logic [NCAND-1:0]  cand_en;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (v < MAXV) ? v + CW'(1) : MAXV;
	endfunction

	function automatic logic [16:0] to17(input logic [CW-1:0] v);
		logic [OW-1:0] w;
		w = OW'(v);
		return w[16:0];
	endfunction

	function automatic wlst_pkg::record_t make_rec(
		input logic [1:0]    kind,
		input logic [15:0]   start,
		input logic [CW-1:0] length,
		input logic [CW-1:0] nonspace,
		input logic [CW-1:0] words,
		input logic [CW-1:0] lines
	);
		wlst_pkg::record_t r;
		r.kind     = kind;
		r.start    = start;
		r.length   = to17(length);
		r.nonspace = to17(nonspace);
		r.words    = to17(words);
		r.lines    = to17(lines);
		r.last     = 1'b0;
		return r;
	endfunction

	// Position of this unit, held at the last slot once the text is overlong.
	always_comb begin
		logic [OW-1:0] pos_w;
		pos_w = OW'(position_q);
		idx = (position_q < MAXV) ? pos_w[15:0] : LAST_IDX[15:0];
	end

	// Line and word updates for this unit, before any end-of-text flush.
	always_comb begin
		line_close  = unit_class.newline & in_line_q;
		word_close  = unit_class.space & in_word_q;
		in_line1    = ~unit_class.newline;
		in_word1    = ~unit_class.space;
		line_begin1 = (!unit_class.newline && !in_line_q) ? idx : line_begin_q;
		word_begin1 = (!unit_class.space && !in_word_q) ? idx : word_begin_q;
		line_run1   = unit_class.newline ? '0 : sat_inc(line_run_q);
		word_run1   = unit_class.space ? '0 : sat_inc(word_run_q);
		nonspace1   = unit_class.space ? nonspace_q : sat_inc(nonspace_q);
		lines1      = line_close ? sat_inc(lines_q) : lines_q;
		words1      = word_close ? sat_inc(words_q) : words_q;
		lines_f     = (end_of_text && in_line1) ? sat_inc(lines1) : lines1;
		words_f     = (end_of_text && in_word1) ? sat_inc(words1) : words1;
	end

	// Candidate records in emission order.
	always_comb begin
		cand[0] = make_rec(wlst_pkg::KIND_LINE, line_begin_q, line_run_q,
			nonspace_q, words_q, lines1);
		cand[1] = make_rec(wlst_pkg::KIND_WORD, word_begin_q, word_run_q,
			nonspace1, words1, lines1);
		cand[2] = make_rec(wlst_pkg::KIND_LINE, line_begin1, line_run1,
			nonspace1, words1, lines_f);
		cand[3] = make_rec(wlst_pkg::KIND_WORD, word_begin1, word_run1,
			nonspace1, words_f, lines_f);
		cand[4] = make_rec(wlst_pkg::KIND_TOTAL, 16'd0, '0,
			nonspace1, words_f, lines_f);
		cand_en = {end_of_text, end_of_text & in_word1, end_of_text & in_line1,
			word_close, line_close};
	end

	// Pack the enabled candidates into the front of the record list.
	always_comb begin
		logic [2:0] cnt;
		cnt = 3'd0;
		for (int i = 0; i < wlst_pkg::MAX_RECS; i++) begin
			recs[i] = '0;
		end
		for (int i = 0; i < NCAND; i++) begin
			if (cand_en[i]) begin
				if (cnt < 3'(wlst_pkg::MAX_RECS)) begin
					recs[cnt[1:0]] = cand[i];
				end
				cnt = cnt + 3'd1;
			end
		end
		rec_count = cnt[1:0];
	end

	// State moves on when the unit retires; end of text starts a fresh text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_line_q    <= 1'b0;
			in_word_q    <= 1'b0;
			line_begin_q <= '0;
			word_begin_q <= '0;
			line_run_q   <= '0;
			word_run_q   <= '0;
			position_q   <= '0;
			nonspace_q   <= '0;
			words_q      <= '0;
			lines_q      <= '0;
		end else if (retire) begin
			if (end_of_text) begin
				in_line_q    <= 1'b0;
				in_word_q    <= 1'b0;
				line_begin_q <= '0;
				word_begin_q <= '0;
				line_run_q   <= '0;
				word_run_q   <= '0;
				position_q   <= '0;
				nonspace_q   <= '0;
				words_q      <= '0;
				lines_q      <= '0;
			end else begin
				in_line_q    <= in_line1;
				in_word_q    <= in_word1;
				line_begin_q <= line_begin1;
				word_begin_q <= word_begin1;
				line_run_q   <= line_run1;
				word_run_q   <= word_run1;
				position_q   <= sat_inc(position_q);
				nonspace_q   <= nonspace1;
				words_q      <= words1;
				lines_q      <= lines1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/word_line_span_tokenizer_top.sv
// Top level of the word and line span tokenizer.
// Units are held in the input register; records are offered from the output register.
// Throughput: one code unit per cycle while each unit causes at most one record and the
// output is not stalled; a unit that causes several records holds the input register
// until its last one is emitted; the single output register takes one record per cycle.
// Reset: arst_n clears the pipeline valids, the record phase, all text state and the mode.
`default_nettype none

module word_line_span_tokenizer_top #(
	parameter int unsigned MAX_TEXT_UNITS = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] code_unit,
	input  wire logic        end_of_text,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       record_kind,
	output logic [15:0]      span_start,
	output logic [16:0]      span_length,
	output logic [16:0]      nonspace_total,
	output logic [16:0]      word_total,
	output logic [16:0]      line_total,
	output logic             last_record
);

	logic        extended_q;
	logic        valid_s1;
	logic [15:0] code_unit_s1;
	logic        eot_s1;
	logic [1:0]  phase_q;
	logic        rec_valid_q;

	wlst_pkg::unit_class_t unit_class;
	wlst_pkg::record_t     recs [wlst_pkg::MAX_RECS];
	wlst_pkg::record_t     rec_q;
	wlst_pkg::record_t     rec_next;
	logic [1:0]            rec_count;
	logic                  slot_free;
	logic                  last_phase;
	logic                  emit;
	logic                  retire;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extended_q <= 1'b0;
		end else if (cfg_we) begin
			extended_q <= cfg_wdata;
		end
	end

	wlst_classify u_classify (
		.code_unit  (code_unit_s1),
		.extended   (extended_q),
		.unit_class (unit_class)
	);

	wlst_span_state #(
		.MAX_TEXT_UNITS (MAX_TEXT_UNITS)
	) u_span_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.unit_class  (unit_class),
		.end_of_text (eot_s1),
		.retire      (retire),
		.recs        (recs),
		.rec_count   (rec_count)
	);

	// Handshake control: one record per cycle into the output register while it has room.
	always_comb begin
		slot_free  = !rec_valid_q || out_ready;
		last_phase = (phase_q == (rec_count - 2'd1));
		emit       = valid_s1 && (rec_count != 2'd0) && slot_free;
		retire     = valid_s1 && ((rec_count == 2'd0) || (slot_free && last_phase));
		in_ready   = !valid_s1 || retire;
	end

	// Record selected for this phase, marked when it ends the request.
	always_comb begin
		rec_next      = recs[phase_q];
		rec_next.last = last_phase;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			code_unit_s1 <= code_unit;
			eot_s1       <= end_of_text;
		end
	end

	// Record phase within the current unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
		end else if (retire) begin
			phase_q <= 2'd0;
		end else if (emit) begin
			phase_q <= phase_q + 2'd1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (emit) begin
			rec_valid_q <= 1'b1;
		end else if (out_ready) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rec_q <= rec_next;
		end
	end

	assign out_valid      = rec_valid_q;
	assign record_kind    = rec_q.kind;
	assign span_start     = rec_q.start;
	assign span_length    = rec_q.length;
	assign nonspace_total = rec_q.nonspace;
	assign word_total     = rec_q.words;
	assign line_total     = rec_q.lines;
	assign last_record    = rec_q.last;

endmodule

`default_nettype wire

>>> rtl/core/wlst_checker.sv
// Port-level checks of the tokenizer and their binding to the top level.
`default_nettype none

module wlst_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  record_kind,
	input wire logic [15:0] span_start,
	input wire logic [16:0] span_length,
	input wire logic        last_record
);

	// A stalled record holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(record_kind)
			&& $stable(span_start) && $stable(span_length) && $stable(last_record))
		else $error("stalled output record changed");

	// A totals record always ends the records of its request.
	a_total_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (record_kind == wlst_pkg::KIND_TOTAL) |-> last_record)
		else $error("totals record not marked last");

	// A totals record carries no span.
	a_total_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (record_kind == wlst_pkg::KIND_TOTAL) |->
			(span_start == 16'd0) && (span_length == 17'd0))
		else $error("totals record carries a span");

	// A line or word span always covers at least one unit.
	a_span_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((record_kind == wlst_pkg::KIND_LINE)
			|| (record_kind == wlst_pkg::KIND_WORD)) |-> (span_length != 17'd0))
		else $error("empty span record");

endmodule

bind word_line_span_tokenizer_top wlst_checker u_wlst_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.record_kind (record_kind),
	.span_start  (span_start),
	.span_length (span_length),
	.last_record (last_record)
);

`default_nettype wire

>>> sim/word_line_span_tokenizer_top_tb.sv
// Self-checking testbench for the word and line span tokenizer top level.
`default_nettype none

module word_line_span_tokenizer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TEXT_LIMIT = 65536;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned RANDOM_UNITS_PER_PHASE = 62;

	// Records that one code unit is predicted to cause, first record at index 0.
	typedef struct packed {
		logic [1:0]                  count;
		wlst_pkg::record_t [2:0]     recs;
	} unit_records_t;

	// One row of the directed table.
	typedef struct packed {
		logic          set_mode;
		logic          mode;
		logic [15:0]   cu;
		logic          eot;
		unit_records_t fixed;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [15:0] code_unit;
	logic end_of_text;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] record_kind;
	logic [15:0] span_start;
	logic [16:0] span_length;
	logic [16:0] nonspace_total;
	logic [16:0] word_total;
	logic [16:0] line_total;
	logic last_record;

	// Hand-written expectation that travels with a directed request.
	unit_records_t fixed_due;

	int unsigned send_idle_pct = 7;
	int unsigned recv_idle_pct = 67;
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;

	// Predictor copy of the mode register and of the text state.
	logic ext_mode = 1'b0;
	logic line_open = 1'b0;
	logic word_open = 1'b0;
	logic [15:0] line_head = '0;
	logic [15:0] word_head = '0;
	logic [16:0] line_len = '0;
	logic [16:0] word_len = '0;
	logic [16:0] text_pos = '0;
	logic [16:0] nonspace_seen = '0;
	logic [16:0] words_seen = '0;
	logic [16:0] lines_seen = '0;

	wlst_pkg::record_t records_due[$];

	word_line_span_tokenizer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.code_unit(code_unit),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.record_kind(record_kind),
		.span_start(span_start),
		.span_length(span_length),
		.nonspace_total(nonspace_total),
		.word_total(word_total),
		.line_total(line_total),
		.last_record(last_record)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [16:0] bump(logic [16:0] v);
		return (v < TEXT_LIMIT) ? v + 17'd1 : 17'(TEXT_LIMIT);
	endfunction

	function automatic wlst_pkg::record_t mk_record(logic [1:0] k, logic [15:0] s,
			logic [16:0] l, logic [16:0] ns, logic [16:0] w, logic [16:0] ln, logic lst);
		wlst_pkg::record_t r;
		r.kind = k;
		r.start = s;
		r.length = l;
		r.nonspace = ns;
		r.words = w;
		r.lines = ln;
		r.last = lst;
		return r;
	endfunction

	function automatic unit_records_t typed(logic [1:0] n, wlst_pkg::record_t a,
			wlst_pkg::record_t b = '0, wlst_pkg::record_t c = '0);
		unit_records_t u;
		u.count = n;
		u.recs[0] = a;
		u.recs[1] = b;
		u.recs[2] = c;
		return u;
	endfunction

	function automatic dir_row_t row(logic set_mode, logic mode, logic [15:0] cu, logic eot,
			unit_records_t fixed = '0);
		dir_row_t d;
		d.set_mode = set_mode;
		d.mode = mode;
		d.cu = cu;
		d.eot = eot;
		d.fixed = fixed;
		return d;
	endfunction

	// Appends a span record stamped with the running totals.
	function automatic void append_span(inout unit_records_t res, input logic [1:0] k,
			input logic [15:0] s, input logic [16:0] l);
		res.recs[res.count] = mk_record(k, s, l, nonspace_seen, words_seen, lines_seen, 1'b0);
		res.count = res.count + 2'd1;
	endfunction

	// Advances the text state by one code unit and returns the records it causes.
	function automatic unit_records_t tokenize_unit(logic [15:0] cu, logic eot);
		unit_records_t res;
		logic [15:0] slot;
		logic breaks_line;
		logic breaks_word;
		res = '0;
		breaks_line = (cu == wlst_pkg::CU_CR) || (cu == wlst_pkg::CU_LF) ||
			(ext_mode && (cu == wlst_pkg::CU_LSEP || cu == wlst_pkg::CU_PSEP ||
			cu == wlst_pkg::CU_NEL));
		breaks_word = breaks_line || cu == wlst_pkg::CU_SPACE || cu == wlst_pkg::CU_TAB;
		// Past the limit every unit takes the last position.
		slot = (text_pos < TEXT_LIMIT) ? text_pos[15:0] : 16'hFFFF;
		text_pos = bump(text_pos);

		if (breaks_line) begin
			if (line_open) begin
				lines_seen = bump(lines_seen);
				append_span(res, wlst_pkg::KIND_LINE, line_head, line_len);
				line_open = 1'b0;
				line_len = '0;
			end
		end else begin
			if (!line_open) begin
				line_open = 1'b1;
				line_head = slot;
			end
			line_len = bump(line_len);
		end

		if (breaks_word) begin
			if (word_open) begin
				words_seen = bump(words_seen);
				append_span(res, wlst_pkg::KIND_WORD, word_head, word_len);
				word_open = 1'b0;
				word_len = '0;
			end
		end else begin
			if (!word_open) begin
				word_open = 1'b1;
				word_head = slot;
			end
			word_len = bump(word_len);
			nonspace_seen = bump(nonspace_seen);
		end

		// The last unit flushes whatever is open, reports totals and starts a new text.
		if (eot) begin
			if (line_open) begin
				lines_seen = bump(lines_seen);
				append_span(res, wlst_pkg::KIND_LINE, line_head, line_len);
			end
			if (word_open) begin
				words_seen = bump(words_seen);
				append_span(res, wlst_pkg::KIND_WORD, word_head, word_len);
			end
			append_span(res, wlst_pkg::KIND_TOTAL, '0, '0);
			line_open = 1'b0;
			word_open = 1'b0;
			line_head = '0;
			word_head = '0;
			line_len = '0;
			word_len = '0;
			text_pos = '0;
			nonspace_seen = '0;
			words_seen = '0;
			lines_seen = '0;
		end

		if (res.count != 0)
			res.recs[res.count - 2'd1].last = 1'b1;
		return res;
	endfunction

	function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Random code unit, weighted toward letters and the separator sets.
	function automatic logic [15:0] pick_unit();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 40)
			return 16'h0061 + 16'($urandom_range(25));
		else if (r < 52)
			return wlst_pkg::CU_SPACE;
		else if (r < 58)
			return wlst_pkg::CU_TAB;
		else if (r < 66)
			return wlst_pkg::CU_LF;
		else if (r < 72)
			return wlst_pkg::CU_CR;
		else if (r < 76)
			return wlst_pkg::CU_LSEP;
		else if (r < 80)
			return wlst_pkg::CU_PSEP;
		else if (r < 84)
			return wlst_pkg::CU_NEL;
		return 16'($urandom_range(16'hFFFF));
	endfunction

	// Receiver: stalls at random according to the current idle rate.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Checks accepted records, predicts accepted requests and guards against hangs.
	always @(posedge clk) begin : monitor
		unit_records_t due;
		wlst_pkg::record_t want;
		if (arst_n) begin
			if (cfg_we)
				ext_mode = cfg_wdata;

			if (out_valid && out_ready) begin
				if (records_due.size() == 0) begin
					$error("record_kind: expected no record, got %0d", record_kind);
					mismatches++;
				end else begin
					want = records_due.pop_front();
					check_field("record_kind", 17'(want.kind), 17'(record_kind));
					check_field("span_start", 17'(want.start), 17'(span_start));
					check_field("span_length", want.length, span_length);
					check_field("nonspace_total", want.nonspace, nonspace_total);
					check_field("word_total", want.words, word_total);
					check_field("line_total", want.lines, line_total);
					check_field("last_record", 17'(want.last), 17'(last_record));
				end
			end

			if (in_valid && in_ready) begin
				due = tokenize_unit(code_unit, end_of_text);
				if (fixed_due.count != 0)
					due = fixed_due;
				for (int k = 0; k < int'(due.count); k++)
					records_due.insert(records_due.size(), due.recs[k]);
			end

			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("word_line_span_tokenizer_top verification failed");
				$finish;
			end
		end
	end

	// Offers one request, idling first at random; returns at the falling edge after acceptance.
	task automatic push_unit(logic [15:0] cu, logic eot, unit_records_t fixed);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		code_unit <= cu;
		end_of_text <= eot;
		fixed_due <= fixed;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Waits until every predicted record has arrived and the pipeline has emptied.
	task automatic settle();
		in_valid <= 1'b0;
		while (records_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_mode(logic mode);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		dir_row_t directed_rows[$];
		int unsigned sent;
		int unsigned len;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		code_unit = '0;
		end_of_text = 1'b0;
		fixed_due = '0;

		// Single-unit texts, a basic-mode text, an extended-mode text, then another single-unit text.
		directed_rows = '{
			row(1'b0, 1'b0, wlst_pkg::CU_SPACE, 1'b1,
				typed(2'd2,
					mk_record(wlst_pkg::KIND_LINE, 16'd0, 17'd1, 17'd0, 17'd0, 17'd1, 1'b0),
					mk_record(wlst_pkg::KIND_TOTAL, 16'd0, 17'd0, 17'd0, 17'd0, 17'd1,
						1'b1))),
			row(1'b0, 1'b0, 16'h0041, 1'b1,
				typed(2'd3,
					mk_record(wlst_pkg::KIND_LINE, 16'd0, 17'd1, 17'd1, 17'd0, 17'd1, 1'b0),
					mk_record(wlst_pkg::KIND_WORD, 16'd0, 17'd1, 17'd1, 17'd1, 17'd1, 1'b0),
					mk_record(wlst_pkg::KIND_TOTAL, 16'd0, 17'd0, 17'd1, 17'd1, 17'd1,
						1'b1))),
			row(1'b0, 1'b0, wlst_pkg::CU_LF, 1'b1,
				typed(2'd1,
					mk_record(wlst_pkg::KIND_TOTAL, 16'd0, 17'd0, 17'd0, 17'd0, 17'd0,
						1'b1))),
			row(1'b0, 1'b0, 16'h0068, 1'b0),
			row(1'b0, 1'b0, 16'h0069, 1'b0),
			row(1'b0, 1'b0, wlst_pkg::CU_TAB, 1'b0),
			row(1'b0, 1'b0, 16'h0078, 1'b0),
			row(1'b0, 1'b0, wlst_pkg::CU_CR, 1'b0),
			row(1'b0, 1'b0, wlst_pkg::CU_LF, 1'b0),
			row(1'b0, 1'b0, 16'hFFFF, 1'b0),
			row(1'b0, 1'b0, wlst_pkg::CU_SPACE, 1'b0),
			row(1'b0, 1'b0, 16'h0000, 1'b0),
			row(1'b0, 1'b0, wlst_pkg::CU_LSEP, 1'b0),
			row(1'b0, 1'b0, wlst_pkg::CU_NEL, 1'b0),
			row(1'b0, 1'b0, 16'h8000, 1'b1),
			row(1'b1, 1'b1, 16'h0061, 1'b0),
			row(1'b0, 1'b0, wlst_pkg::CU_LSEP, 1'b0),
			row(1'b0, 1'b0, 16'h0062, 1'b0),
			row(1'b0, 1'b0, wlst_pkg::CU_PSEP, 1'b0),
			row(1'b0, 1'b0, 16'h0063, 1'b0),
			row(1'b0, 1'b0, wlst_pkg::CU_NEL, 1'b0),
			row(1'b0, 1'b0, wlst_pkg::CU_SPACE, 1'b0),
			row(1'b0, 1'b0, 16'h0064, 1'b0),
			row(1'b0, 1'b0, wlst_pkg::CU_PSEP, 1'b1),
			row(1'b0, 1'b0, wlst_pkg::CU_NEL, 1'b1,
				typed(2'd1,
					mk_record(wlst_pkg::KIND_TOTAL, 16'd0, 17'd0, 17'd0, 17'd0, 17'd0,
						1'b1)))
		};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].set_mode) begin
				settle();
				write_mode(directed_rows[i].mode);
			end
			push_unit(directed_rows[i].cu, directed_rows[i].eot, directed_rows[i].fixed);
		end

		// Random texts under three idle patterns, alternating the mode.
		for (int phase = 0; phase < 3; phase++) begin
			settle();
			case (phase)
				0: begin
					send_idle_pct = 7;
					recv_idle_pct = 67;
				end
				1: begin
					send_idle_pct = 67;
					recv_idle_pct = 7;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_mode(phase == 1);
			sent = 0;
			while (sent < RANDOM_UNITS_PER_PHASE) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
				for (int j = 0; j < int'(len); j++)
					push_unit(pick_unit(), j == int'(len) - 1, '0);
				sent += len;
			end
		end

		settle();
		repeat (4) @(negedge clk);
		if (mismatches == 0)
			$display("word_line_span_tokenizer_top verification clean");
		else
			$display("word_line_span_tokenizer_top verification failed");
		$finish;
	end

endmodule

`default_nettype wire
